// ===== design/hscb_pkg.sv =====
// Shared constants for the HSV-space color blend pipeline.
// No dependencies; used by hscb_div and hsv_space_color_blend_unit.
package hscb_pkg;

  localparam int CH_W       = 8;   // width of one color channel
  localparam int DIV_STAGES = 3;   // register stages in each pipelined divider
  localparam int REC_SHIFT  = 32;  // fraction bits of the constant reciprocals

  // floor(2^32 / 255) and floor(2^32 / 7650), used with one correction step
  localparam logic [24:0] RECIP_255  = 25'((64'd1 << REC_SHIFT) / 64'd255);
  localparam logic [19:0] RECIP_7650 = 20'((64'd1 << REC_SHIFT) / 64'd7650);

endpackage

// ===== design/hscb_div.sv =====
// Pipelined restoring divider, DIV_STAGES register stages, several quotient bits per stage.
// Depends on hscb_pkg. The quotient must fit in QW bits; the divisor must be nonzero.
module hscb_div
  import hscb_pkg::*;
#(
  parameter int NW = 17,
  parameter int QW = 9,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int BPS = (QW + DIV_STAGES - 1) / DIV_STAGES;
  localparam int WW  = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r [DIV_STAGES];
  logic [QW-1:0] quo_r [DIV_STAGES];
  logic [DW-1:0] den_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    // quotient bits resolved in this stage; the last stage may take fewer
    localparam int NB = (QW - s * BPS < BPS) ? QW - s * BPS : BPS;

    logic [NW-1:0] rem_in;
    logic [NW-1:0] rem_c;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_c;
    logic [DW-1:0] d_in;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign q_in   = '0;
      assign d_in   = den;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign q_in   = quo_r[s-1];
      assign d_in   = den_r[s-1];
    end

    // Try one shifted divisor per quotient bit, high bit first.
    always_comb begin
      logic [WW-1:0] trial;
      trial = '0;
      rem_c = rem_in;
      q_c   = q_in;
      for (int k = 0; k < NB; k++) begin
        trial = WW'(d_in) << (QW - 1 - s * BPS - k);
        if (WW'(rem_c) >= trial) begin
          rem_c = rem_c - NW'(trial);
          q_c[QW-1-s*BPS-k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_c;
        quo_r[s] <= q_c;
        den_r[s] <= d_in;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

// ===== design/hsv_space_color_blend_unit.sv =====
// HSV-space blend of two RGB colors: RGB->HSV on both, linear blend of H, S, V, HSV->RGB.
// Throughput: one item per clock while no result is stalled; every stage is a register, the dividers are pipelined.
// A stalled output freezes the whole pipeline; in_stall follows out_stall while a result waits.
// Reset (rst_n low, synchronous) clears only the valid bits; payload registers are not reset.
// Depends on hscb_pkg and hscb_div.
module hsv_space_color_blend_unit
  import hscb_pkg::*;
#(
  parameter int AMOUNT_FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CH_W-1:0]           in_start_red,
  input  logic [CH_W-1:0]           in_start_green,
  input  logic [CH_W-1:0]           in_start_blue,
  input  logic [CH_W-1:0]           in_end_red,
  input  logic [CH_W-1:0]           in_end_green,
  input  logic [CH_W-1:0]           in_end_blue,
  input  logic [AMOUNT_FRAC_BITS:0] in_blend_amount,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CH_W-1:0]           out_red,
  output logic [CH_W-1:0]           out_green,
  output logic [CH_W-1:0]           out_blue
);

  localparam int F   = AMOUNT_FRAC_BITS;
  localparam int TW  = F + 1;
  localparam int LAT = 8 + DIV_STAGES;
  localparam logic [TW-1:0] ONE = TW'(1) << F;
  localparam int BW  = CH_W + TW + 1;  // blend accumulator width

  typedef enum logic [1:0] {MAX_RED, MAX_GREEN, MAX_BLUE} maxch_t;
  typedef enum logic [2:0] {SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR} sector_t;

  logic [LAT-1:0] vld_r;
  logic           en;

  // The pipeline moves as one unit; it holds only while a finished result is stalled.
  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = vld_r[LAT-1] && out_stall;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ---------------- Stage 1: capture item, saturate the blend amount ----------------
  logic [1:0][2:0][CH_W-1:0] col1_r;
  logic [TW-1:0]             t1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      col1_r[0] <= {in_start_red, in_start_green, in_start_blue};
      col1_r[1] <= {in_end_red, in_end_green, in_end_blue};
      t1_r      <= (in_blend_amount > ONE) ? ONE : in_blend_amount;
    end
  end

  // ---------------- Stage 2: max, min, spread, dominant channel ----------------
  logic [1:0][2:0][CH_W-1:0] col2_r;
  logic [1:0][CH_W-1:0]      mx2_r;
  logic [1:0][CH_W-1:0]      d2_r;
  maxch_t                    sel2_r [2];
  logic [TW-1:0]             t2_r;

  for (genvar c = 0; c < 2; c++) begin : g_minmax
    logic [CH_W-1:0] r, g, b, mx, mn;
    maxch_t          sel;
    assign r = col1_r[c][2];
    assign g = col1_r[c][1];
    assign b = col1_r[c][0];

    // Ties resolve to red, then green.
    always_comb begin
      mx  = r;
      sel = MAX_RED;
      if (g > mx) begin
        mx  = g;
        sel = MAX_GREEN;
      end
      if (b > mx) begin
        mx  = b;
        sel = MAX_BLUE;
      end
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        col2_r[c] <= col1_r[c];
        mx2_r[c]  <= mx;
        d2_r[c]   <= mx - mn;
        sel2_r[c] <= sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) t2_r <= t1_r;
  end

  // ---------------- Stage 3: divider operands ----------------
  logic [1:0][16:0]     hnum3_r;
  logic [1:0][CH_W-1:0] hden3_r;
  logic [1:0][15:0]     snum3_r;
  logic [1:0][CH_W-1:0] sden3_r;
  logic [1:0][CH_W-1:0] v3_r;
  logic [TW-1:0]        t3_r;

  for (genvar c = 0; c < 2; c++) begin : g_oper
    logic [17:0] r6, g6, b6, d60;
    logic [16:0] hnum;
    assign r6  = 18'(col2_r[c][2]) * 18'd60;
    assign g6  = 18'(col2_r[c][1]) * 18'd60;
    assign b6  = 18'(col2_r[c][0]) * 18'd60;
    assign d60 = 18'(d2_r[c]) * 18'd60;

    // Hue numerator in degrees times spread, already wrapped to be nonnegative.
    always_comb begin
      case (sel2_r[c])
        MAX_RED: begin
          if (g6 >= b6) hnum = 17'(g6 - b6);
          else          hnum = 17'(d60 * 18'd6 + g6 - b6);
        end
        MAX_GREEN: hnum = 17'(d60 * 18'd2 + b6 - r6);
        MAX_BLUE:  hnum = 17'(d60 * 18'd4 + r6 - g6);
        default:   hnum = '0;
      endcase
    end

    // Gray and black: zero numerators over a unit divisor give hue and saturation zero.
    always_ff @(posedge clk) begin
      if (en) begin
        if (d2_r[c] == '0) begin
          hnum3_r[c] <= '0;
          hden3_r[c] <= CH_W'(1);
          snum3_r[c] <= '0;
          sden3_r[c] <= CH_W'(1);
        end else begin
          hnum3_r[c] <= hnum;
          hden3_r[c] <= d2_r[c];
          snum3_r[c] <= 16'(d2_r[c]) * 16'd255;
          sden3_r[c] <= mx2_r[c];
        end
        v3_r[c] <= mx2_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) t3_r <= t2_r;
  end

  // ---------------- Dividers: hue degrees and saturation ----------------
  logic [1:0][8:0]      hq;
  logic [1:0][CH_W-1:0] sq;

  for (genvar c = 0; c < 2; c++) begin : g_div
    hscb_div #(.NW(17), .QW(9), .DW(CH_W)) u_hue_div (
      .clk (clk),
      .en  (en),
      .num (hnum3_r[c]),
      .den (hden3_r[c]),
      .quo (hq[c])
    );
    hscb_div #(.NW(16), .QW(CH_W), .DW(CH_W)) u_sat_div (
      .clk (clk),
      .en  (en),
      .num (snum3_r[c]),
      .den (sden3_r[c]),
      .quo (sq[c])
    );
  end

  // Carry value and blend amount alongside the dividers.
  logic [1:0][CH_W-1:0] vd_r [DIV_STAGES];
  logic [TW-1:0]        td_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      vd_r[0] <= v3_r;
      td_r[0] <= t3_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        vd_r[i] <= vd_r[i-1];
        td_r[i] <= td_r[i-1];
      end
    end
  end

  // ---------------- Stage 7: linear blend of H, S, V ----------------
  logic [CH_W-1:0] h7_r, s7_r, v7_r;
  logic [TW-1:0]   tb, tinv;
  logic [CH_W-1:0] h_a, h_b;
  logic [BW-1:0]   h_acc, s_acc, v_acc;

  assign tb   = td_r[DIV_STAGES-1];
  assign tinv = ONE - tb;
  assign h_a  = CH_W'(hq[0] >> 1);  // hue in units of two degrees
  assign h_b  = CH_W'(hq[1] >> 1);

  assign h_acc = BW'(h_a) * BW'(tinv) + BW'(h_b) * BW'(tb);
  assign s_acc = BW'(sq[0]) * BW'(tinv) + BW'(sq[1]) * BW'(tb);
  assign v_acc = BW'(vd_r[DIV_STAGES-1][0]) * BW'(tinv)
               + BW'(vd_r[DIV_STAGES-1][1]) * BW'(tb);

  always_ff @(posedge clk) begin
    if (en) begin
      h7_r <= h_acc[F+CH_W-1:F];
      s7_r <= s_acc[F+CH_W-1:F];
      v7_r <= v_acc[F+CH_W-1:F];
    end
  end

  // ---------------- Stage 8: sector, fraction, factor terms ----------------
  sector_t         sec8_r;
  logic [CH_W-1:0] v8_r;
  logic [CH_W-1:0] a1_8_r;
  logic [12:0]     a2_8_r, a3_8_r;
  sector_t         sec;
  logic [4:0]      fr;

  // Sector = floor(h/30) reduced modulo 6; fr = h - 30*floor(h/30).
  always_comb begin
    if      (h7_r < 8'd30)  begin sec = SEC_RY; fr = 5'(h7_r);          end
    else if (h7_r < 8'd60)  begin sec = SEC_YG; fr = 5'(h7_r - 8'd30);  end
    else if (h7_r < 8'd90)  begin sec = SEC_GC; fr = 5'(h7_r - 8'd60);  end
    else if (h7_r < 8'd120) begin sec = SEC_CB; fr = 5'(h7_r - 8'd90);  end
    else if (h7_r < 8'd150) begin sec = SEC_BM; fr = 5'(h7_r - 8'd120); end
    else if (h7_r < 8'd180) begin sec = SEC_MR; fr = 5'(h7_r - 8'd150); end
    else if (h7_r < 8'd210) begin sec = SEC_RY; fr = 5'(h7_r - 8'd180); end
    else if (h7_r < 8'd240) begin sec = SEC_YG; fr = 5'(h7_r - 8'd210); end
    else                    begin sec = SEC_GC; fr = 5'(h7_r - 8'd240); end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec8_r <= sec;
      v8_r   <= v7_r;
      a1_8_r <= 8'd255 - s7_r;
      a2_8_r <= 13'd7650 - 13'(s7_r) * 13'(fr);
      a3_8_r <= 13'd7650 - 13'(s7_r) * 13'(5'd30 - fr);
    end
  end

  // ---------------- Stage 9: scale by value ----------------
  sector_t         sec9_r;
  logic [CH_W-1:0] v9_r;
  logic [15:0]     xp9_r;
  logic [20:0]     xq9_r, xt9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sec9_r <= sec8_r;
      v9_r   <= v8_r;
      xp9_r  <= 16'(v8_r) * 16'(a1_8_r);
      xq9_r  <= 21'(v8_r) * 21'(a2_8_r);
      xt9_r  <= 21'(v8_r) * 21'(a3_8_r);
    end
  end

  // ---------------- Stage 10: reciprocal estimates of the quotients ----------------
  sector_t         sec10_r;
  logic [CH_W-1:0] v10_r;
  logic [15:0]     xp10_r;
  logic [20:0]     xq10_r, xt10_r;
  logic [CH_W-1:0] qp10_r, qq10_r, qt10_r;
  logic [47:0]     mp, mq, mt;

  assign mp = 48'(xp9_r) * 48'(RECIP_255);
  assign mq = 48'(xq9_r) * 48'(RECIP_7650);
  assign mt = 48'(xt9_r) * 48'(RECIP_7650);

  always_ff @(posedge clk) begin
    if (en) begin
      sec10_r <= sec9_r;
      v10_r   <= v9_r;
      xp10_r  <= xp9_r;
      xq10_r  <= xq9_r;
      xt10_r  <= xt9_r;
      qp10_r  <= mp[REC_SHIFT+CH_W-1:REC_SHIFT];
      qq10_r  <= mq[REC_SHIFT+CH_W-1:REC_SHIFT];
      qt10_r  <= mt[REC_SHIFT+CH_W-1:REC_SHIFT];
    end
  end

  // ---------------- Stage 11: correct estimates, pick channels by sector ----------------
  logic [15:0]     rp;
  logic [20:0]     rq, rt;
  logic [CH_W-1:0] p, q, t;

  // The estimate is low by at most one; bump it when the remainder reaches the divisor.
  assign rp = xp10_r - 16'(qp10_r) * 16'd255;
  assign rq = xq10_r - 21'(qq10_r) * 21'd7650;
  assign rt = xt10_r - 21'(qt10_r) * 21'd7650;
  assign p  = (rp >= 16'd255)  ? qp10_r + 8'd1 : qp10_r;
  assign q  = (rq >= 21'd7650) ? qq10_r + 8'd1 : qq10_r;
  assign t  = (rt >= 21'd7650) ? qt10_r + 8'd1 : qt10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      case (sec10_r)
        SEC_RY: begin out_red <= v10_r; out_green <= t;     out_blue <= p;     end
        SEC_YG: begin out_red <= q;     out_green <= v10_r; out_blue <= p;     end
        SEC_GC: begin out_red <= p;     out_green <= v10_r; out_blue <= t;     end
        SEC_CB: begin out_red <= p;     out_green <= q;     out_blue <= v10_r; end
        SEC_BM: begin out_red <= t;     out_green <= p;     out_blue <= v10_r; end
        default: begin out_red <= v10_r; out_green <= p;    out_blue <= q;     end
      endcase
    end
  end

endmodule

// ===== dv/hsv_space_color_blend_unit_test.sv =====
// Self-checking testbench for hsv_space_color_blend_unit: a table of directed items,
// then random items, each checked against an HSV-blend predictor written here.
// Depends on hscb_pkg and the RTL of hsv_space_color_blend_unit.
module hsv_space_color_blend_unit_test
  import hscb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC      = 8;
  localparam int BLEND_ONE = 1 << FRAC;
  localparam int N_RANDOM  = 1130;
  localparam int CALM_TAIL = 150;     // last items run with no idling
  localparam int LATENCY   = 8 + DIV_STAGES;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [CH_W-1:0] chan_t;
  typedef logic [FRAC:0]   amt_t;
  typedef struct packed {
    chan_t r, g, b;
  } rgb_t;
  typedef struct packed {
    rgb_t            c0, c1;
    logic [FRAC:0]   amt;
  } blend_item_t;
  // one directed row; has_exp marks a result that can be typed in
  typedef struct {
    blend_item_t it;
    bit          has_exp;
    rgb_t        exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  chan_t in_start_red = '0, in_start_green = '0, in_start_blue = '0;
  chan_t in_end_red = '0, in_end_green = '0, in_end_blue = '0;
  logic [FRAC:0] in_blend_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  chan_t out_red, out_green, out_blue;

  rgb_t  blended_q[$];
  int    fail_count = 0;
  int    cycle_count = 0;
  bit    calm = 1'b0;

  always #5 clk = ~clk;

  hsv_space_color_blend_unit #(.AMOUNT_FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_red(in_start_red), .in_start_green(in_start_green),
    .in_start_blue(in_start_blue), .in_end_red(in_end_red),
    .in_end_green(in_end_green), .in_end_blue(in_end_blue),
    .in_blend_amount(in_blend_amount),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

  // RGB to 8-bit HSV; gray and black give hue 0 and saturation 0
  function automatic void rgb_to_hsv(input rgb_t c, output int h, output int s,
                                     output int v);
    int mx, mn, d, num;
    mx = c.r; mn = c.r;
    if (c.g > mx) mx = c.g;
    if (c.b > mx) mx = c.b;
    if (c.g < mn) mn = c.g;
    if (c.b < mn) mn = c.b;
    v = mx;
    h = 0;
    s = 0;
    if (mx != mn) begin
      d = mx - mn;
      s = (255 * d) / mx;
      // red wins ties, then green
      if (mx == c.r) num = 60 * (int'(c.g) - int'(c.b));
      else if (mx == c.g) num = 60 * (int'(c.b) - int'(c.r)) + 120 * d;
      else num = 60 * (int'(c.r) - int'(c.g)) + 240 * d;
      if (num < 0) num += 360 * d;
      h = num / (2 * d);
    end
  endfunction

  function automatic int mix(input int a, input int b, input int t);
    return (a * (BLEND_ONE - t) + b * t) >> FRAC;
  endfunction

  function automatic rgb_t hsv_blend(input blend_item_t it);
    int h0, s0, v0, h1, s1, v1, h, s, v, t, sec, fr, p, q, tt;
    rgb_t o;
    t = (it.amt > BLEND_ONE) ? BLEND_ONE : it.amt;   // saturate the amount
    rgb_to_hsv(it.c0, h0, s0, v0);
    rgb_to_hsv(it.c1, h1, s1, v1);
    h = mix(h0, h1, t);
    s = mix(s0, s1, t);
    v = mix(v0, v1, t);
    sec = h / 30;
    fr = h - 30 * sec;
    sec = sec % 6;
    p  = (v * (255 - s)) / 255;
    q  = (v * (7650 - s * fr)) / 7650;
    tt = (v * (7650 - s * (30 - fr))) / 7650;
    case (sec)
      0: o = '{chan_t'(v), chan_t'(tt), chan_t'(p)};
      1: o = '{chan_t'(q), chan_t'(v), chan_t'(p)};
      2: o = '{chan_t'(p), chan_t'(v), chan_t'(tt)};
      3: o = '{chan_t'(p), chan_t'(q), chan_t'(v)};
      4: o = '{chan_t'(tt), chan_t'(p), chan_t'(v)};
      default: o = '{chan_t'(v), chan_t'(p), chan_t'(q)};
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
             want);
    fail_count++;
  endtask

  // Drive one item and hold it until accepted; idle at random beforehand.
  task automatic send_item(input blend_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_red <= it.c0.r;
    in_start_green <= it.c0.g;
    in_start_blue <= it.c0.b;
    in_end_red <= it.c1.r;
    in_end_green <= it.c1.g;
    in_end_blue <= it.c1.b;
    in_blend_amount <= it.amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic blend_item_t random_item();
    blend_item_t it;
    it.c0 = 24'($urandom);
    it.c1 = 24'($urandom);
    case ($urandom_range(0, 9))
      0: it.c0 = '{it.c0.r, it.c0.r, it.c0.r};          // gray start
      1: it.c1 = '{it.c1.g, it.c1.g, it.c1.b};          // red/green tie
      2: it.c0.b = it.c0.r;                             // red/blue tie
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: it.amt = amt_t'($urandom_range(BLEND_ONE + 1, 2 * BLEND_ONE - 1));
      1: it.amt = ($urandom_range(0, 1) != 0) ? amt_t'(BLEND_ONE) : amt_t'(0);
      default: it.amt = amt_t'($urandom_range(0, BLEND_ONE));
    endcase
    return it;
  endfunction

  // Result side: check each accepted item against the oldest expectation.
  always @(posedge clk) begin
    rgb_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (blended_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_red, 0);
      end else begin
        want = blended_q.pop_front();
        if (out_red !== want.r) report_mismatch("red", out_red, want.r);
        if (out_green !== want.g) report_mismatch("green", out_green, want.g);
        if (out_blue !== want.b) report_mismatch("blue", out_blue, want.b);
      end
    end
  end

  // Random stall bursts, with calm stretches between them, until the calm tail begins.
  initial begin
    int len;
    @(posedge rst_n);
    while (!calm) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    blend_item_t it;
    int k, wait_cycles;
    // Directed rows: extremes, gray, ties, hue sectors 0 to 4, amount saturation.
    row.has_exp = 1'b1;
    row.it = '{'{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, 9'd0};
    row.exp = '{8'd0, 8'd0, 8'd0};
    rows.push_back(row);
    row.it = '{'{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd0}, 9'd0};
    row.exp = '{8'd255, 8'd255, 8'd255};
    rows.push_back(row);
    row.it = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, 9'd256};
    row.exp = '{8'd255, 8'd255, 8'd255};
    rows.push_back(row);
    row.it = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, 9'd511};
    row.exp = '{8'd255, 8'd255, 8'd255};
    rows.push_back(row);
    row.it = '{'{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd255}, 9'd0};
    row.exp = '{8'd255, 8'd0, 8'd0};
    rows.push_back(row);
    row.it = '{'{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0}, 9'd300};
    row.exp = '{8'd0, 8'd255, 8'd0};
    rows.push_back(row);
    row.it = '{'{8'd128, 8'd128, 8'd128}, '{8'd0, 8'd0, 8'd0}, 9'd0};
    row.exp = '{8'd128, 8'd128, 8'd128};
    rows.push_back(row);
    row.has_exp = 1'b0;
    row.it = '{'{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd255}, 9'd128};
    rows.push_back(row);
    row.it = '{'{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255}, 9'd100};
    rows.push_back(row);
    row.it = '{'{8'd200, 8'd200, 8'd10}, '{8'd10, 8'd200, 8'd200}, 9'd1};
    rows.push_back(row);
    row.it = '{'{8'd255, 8'd10, 8'd255}, '{8'd40, 8'd255, 8'd40}, 9'd255};
    rows.push_back(row);
    row.it = '{'{8'd255, 8'd0, 8'd128}, '{8'd0, 8'd0, 8'd1}, 9'd200};
    rows.push_back(row);
    row.it = '{'{8'd0, 8'd128, 8'd255}, '{8'd128, 8'd0, 8'd255}, 9'd64};
    rows.push_back(row);
    row.it = '{'{8'd255, 8'd255, 8'd254}, '{8'd1, 8'd0, 8'd0}, 9'd170};
    rows.push_back(row);
    row.it = '{'{8'd170, 8'd85, 8'd0}, '{8'd0, 8'd85, 8'd170}, 9'd511};
    rows.push_back(row);
    row.it = '{'{8'd255, 8'd0, 8'd255}, '{8'd255, 8'd0, 8'd0}, 9'd257};
    rows.push_back(row);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table; a typed-in result must also agree with the predictor.
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        blended_q.push_back(rows[i].exp);
        if (hsv_blend(rows[i].it) != rows[i].exp)
          report_mismatch("table row", i, 0);
      end else begin
        blended_q.push_back(hsv_blend(rows[i].it));
      end
      send_item(rows[i].it);
    end

    for (k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - CALM_TAIL) calm = 1'b1;
      it = random_item();
      blended_q.push_back(hsv_blend(it));
      send_item(it);
    end
    in_valid <= 1'b0;

    // Drain, then give stray results a chance to show.
    while (blended_q.size() != 0) @(posedge clk);
    for (wait_cycles = 0; wait_cycles < 2 * LATENCY; wait_cycles++) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hscb_pkg.sv
design/hscb_div.sv
design/hsv_space_color_blend_unit.sv
dv/hsv_space_color_blend_unit_test.sv
